### sv/pixel_blend_modes_premultiplied_assert.svh
// assertion macros for the premultiplied pixel blender checker
// expects clk and rst_n in the scope where a macro is used
`ifndef PIXEL_BLEND_MODES_PREMULTIPLIED_ASSERT_SVH
`define PIXEL_BLEND_MODES_PREMULTIPLIED_ASSERT_SVH

// same-cycle implication
`define PBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbm same-cycle check failed");

// next-cycle implication
`define PBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbm next-cycle check failed");

`endif

### sv/pbm_pkg.sv
// shared types, codes and arithmetic helpers for the premultiplied pixel blender
// no dependencies
package pbm_pkg;

  localparam int PIPE_DEPTH = 11;

  // blend mode codes
  localparam logic [3:0] BM_ERASE    = 4'd0;
  localparam logic [3:0] BM_NORMAL   = 4'd1;
  localparam logic [3:0] BM_MULTIPLY = 4'd2;
  localparam logic [3:0] BM_SCREEN   = 4'd3;
  localparam logic [3:0] BM_DIVIDE   = 4'd4;
  localparam logic [3:0] BM_BURN     = 4'd5;
  localparam logic [3:0] BM_DODGE    = 4'd6;
  localparam logic [3:0] BM_DARKEN   = 4'd7;
  localparam logic [3:0] BM_LIGHTEN  = 4'd8;
  localparam logic [3:0] BM_SUBTRACT = 4'd9;
  localparam logic [3:0] BM_ADD      = 4'd10;
  localparam logic [3:0] BM_RECOLOR  = 4'd11;
  localparam logic [3:0] BM_BEHIND   = 4'd12;
  localparam logic [3:0] BM_REPLACE  = 4'd13;

  // register indexes
  localparam logic CFG_IDX_MODE    = 1'b0;
  localparam logic CFG_IDX_OPACITY = 1'b1;

  localparam logic [3:0] RESET_MODE    = BM_NORMAL;
  localparam logic [7:0] RESET_OPACITY = 8'd255;

  typedef struct packed {
    logic [31:0] dest_pixel;
    logic [31:0] src_pixel;
    logic        last_in_run;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic        last_out;
  } out_beat_t;

  // per-pixel context carried down the separable pipe
  typedef struct packed {
    logic        last;
    logic        use_sep;
    logic [31:0] simp;
    logic [7:0]  ua;
    logic [7:0]  a;
  } ctx_t;

  // reciprocal table for unpremultiply, entries for alpha 0 and 255 are zero and unused
  localparam logic [31:0] INV_K = 32'h00FF00FF;
  localparam logic [31:0] INV_TAB [0:255] = '{
    32'd0,     INV_K/1,   INV_K/2,   INV_K/3,   INV_K/4,   INV_K/5,   INV_K/6,   INV_K/7,
    INV_K/8,   INV_K/9,   INV_K/10,  INV_K/11,  INV_K/12,  INV_K/13,  INV_K/14,  INV_K/15,
    INV_K/16,  INV_K/17,  INV_K/18,  INV_K/19,  INV_K/20,  INV_K/21,  INV_K/22,  INV_K/23,
    INV_K/24,  INV_K/25,  INV_K/26,  INV_K/27,  INV_K/28,  INV_K/29,  INV_K/30,  INV_K/31,
    INV_K/32,  INV_K/33,  INV_K/34,  INV_K/35,  INV_K/36,  INV_K/37,  INV_K/38,  INV_K/39,
    INV_K/40,  INV_K/41,  INV_K/42,  INV_K/43,  INV_K/44,  INV_K/45,  INV_K/46,  INV_K/47,
    INV_K/48,  INV_K/49,  INV_K/50,  INV_K/51,  INV_K/52,  INV_K/53,  INV_K/54,  INV_K/55,
    INV_K/56,  INV_K/57,  INV_K/58,  INV_K/59,  INV_K/60,  INV_K/61,  INV_K/62,  INV_K/63,
    INV_K/64,  INV_K/65,  INV_K/66,  INV_K/67,  INV_K/68,  INV_K/69,  INV_K/70,  INV_K/71,
    INV_K/72,  INV_K/73,  INV_K/74,  INV_K/75,  INV_K/76,  INV_K/77,  INV_K/78,  INV_K/79,
    INV_K/80,  INV_K/81,  INV_K/82,  INV_K/83,  INV_K/84,  INV_K/85,  INV_K/86,  INV_K/87,
    INV_K/88,  INV_K/89,  INV_K/90,  INV_K/91,  INV_K/92,  INV_K/93,  INV_K/94,  INV_K/95,
    INV_K/96,  INV_K/97,  INV_K/98,  INV_K/99,  INV_K/100, INV_K/101, INV_K/102, INV_K/103,
    INV_K/104, INV_K/105, INV_K/106, INV_K/107, INV_K/108, INV_K/109, INV_K/110, INV_K/111,
    INV_K/112, INV_K/113, INV_K/114, INV_K/115, INV_K/116, INV_K/117, INV_K/118, INV_K/119,
    INV_K/120, INV_K/121, INV_K/122, INV_K/123, INV_K/124, INV_K/125, INV_K/126, INV_K/127,
    INV_K/128, INV_K/129, INV_K/130, INV_K/131, INV_K/132, INV_K/133, INV_K/134, INV_K/135,
    INV_K/136, INV_K/137, INV_K/138, INV_K/139, INV_K/140, INV_K/141, INV_K/142, INV_K/143,
    INV_K/144, INV_K/145, INV_K/146, INV_K/147, INV_K/148, INV_K/149, INV_K/150, INV_K/151,
    INV_K/152, INV_K/153, INV_K/154, INV_K/155, INV_K/156, INV_K/157, INV_K/158, INV_K/159,
    INV_K/160, INV_K/161, INV_K/162, INV_K/163, INV_K/164, INV_K/165, INV_K/166, INV_K/167,
    INV_K/168, INV_K/169, INV_K/170, INV_K/171, INV_K/172, INV_K/173, INV_K/174, INV_K/175,
    INV_K/176, INV_K/177, INV_K/178, INV_K/179, INV_K/180, INV_K/181, INV_K/182, INV_K/183,
    INV_K/184, INV_K/185, INV_K/186, INV_K/187, INV_K/188, INV_K/189, INV_K/190, INV_K/191,
    INV_K/192, INV_K/193, INV_K/194, INV_K/195, INV_K/196, INV_K/197, INV_K/198, INV_K/199,
    INV_K/200, INV_K/201, INV_K/202, INV_K/203, INV_K/204, INV_K/205, INV_K/206, INV_K/207,
    INV_K/208, INV_K/209, INV_K/210, INV_K/211, INV_K/212, INV_K/213, INV_K/214, INV_K/215,
    INV_K/216, INV_K/217, INV_K/218, INV_K/219, INV_K/220, INV_K/221, INV_K/222, INV_K/223,
    INV_K/224, INV_K/225, INV_K/226, INV_K/227, INV_K/228, INV_K/229, INV_K/230, INV_K/231,
    INV_K/232, INV_K/233, INV_K/234, INV_K/235, INV_K/236, INV_K/237, INV_K/238, INV_K/239,
    INV_K/240, INV_K/241, INV_K/242, INV_K/243, INV_K/244, INV_K/245, INV_K/246, INV_K/247,
    INV_K/248, INV_K/249, INV_K/250, INV_K/251, INV_K/252, INV_K/253, INV_K/254, 32'd0
  };

  // rounded divide by 255 of a biased product sum
  function automatic logic [7:0] rnd255(input logic [16:0] c);
    logic [17:0] t;
    t = {1'b0, c} + {9'b0, c[16:8]};
    return t[15:8];
  endfunction

  // rounded 8-bit scale
  function automatic logic [7:0] mul8(input logic [7:0] x, input logic [7:0] y);
    logic [15:0] p;
    p = x * y;
    return rnd255({1'b0, p} + 17'h80);
  endfunction

  // unpremultiply one pixel with its alpha reciprocal
  function automatic logic [31:0] unpremul(input logic [31:0] p, input logic [23:0] inv);
    logic [31:0] r;
    logic [31:0] prod;
    logic [32:0] sum;
    r = {p[31:24], 24'b0};
    for (int k = 0; k < 3; k++) begin
      prod = p[8*k +: 8] * inv;
      sum  = {1'b0, prod} + 33'h8000;
      r[8*k +: 8] = sum[23:16];
    end
    if (p[31:24] == 8'hFF) begin
      r = p;
    end else if (p[31:24] == 8'h00) begin
      r = '0;
    end
    return r;
  endfunction

  // two restoring division steps, shifts sh and sh-1
  function automatic logic [17:0] div_two(input logic [15:0] rem, input logic [8:0] den,
                                          input logic [2:0] sh);
    logic [16:0] d1;
    logic [16:0] d0;
    logic [16:0] r;
    logic        q1;
    logic        q0;
    d1 = {8'b0, den} << sh;
    d0 = {8'b0, den} << (sh - 3'd1);
    r  = {1'b0, rem};
    q1 = (r >= d1);
    if (q1) begin
      r = r - d1;
    end
    q0 = (r >= d0);
    if (q0) begin
      r = r - d0;
    end
    return {q1, q0, r[15:0]};
  endfunction

endpackage

### sv/pixel_blend_modes_premultiplied.sv
// premultiplied argb8888 compositor, eleven-stage pipeline
// depends on pbm_pkg
//
// channel  dir  handshake             payload
// in       in   in_valid/in_ready     in_data (in_beat_t)
// out      out  out_valid/out_ready   out_data (out_beat_t)
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one pixel enters per cycle unless a full pipe is held by a stalled output
// the depth is set by the 8-bit quotient of divide, burn and dodge, two
// bits per stage over four stages, plus unpremultiply, mix and premultiply
// reset is synchronous and clears only the stage valid bits and the settings
// a stalled output holds its beat while bubbles upstream still close up
module pixel_blend_modes_premultiplied import pbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data
);

  logic [3:0] mode_r;
  logic [7:0] opacity_r;

  logic [PIPE_DEPTH:1] v_r;
  logic [PIPE_DEPTH:1] en;

  // stage 1 to 3 registers
  logic [31:0] s1_d_r, s1_s_r;
  logic        s1_last_r;
  logic [31:0] s2_d_r, s2_s_r;
  logic        s2_last_r, s2_gate_r;
  logic [23:0] s2_invd_r, s2_invs_r;
  logic [7:0]  s2_sa_r;
  logic [31:0] s3_d_r, s3_s_r, s3_ud_r, s3_us_r, s3_base_r;
  logic        s3_last_r, s3_gate_r;
  logic [7:0]  s3_kb_r;
  logic [31:0] s3_base_nxt;

  // separable pipe, stage 4 onward
  ctx_t        ctx_r [4:PIPE_DEPTH-1];
  ctx_t        ctx_nxt;
  logic [7:0]  sep_b_r   [4:9][3];
  logic [7:0]  sep_xnd_r [4:8][3];
  logic [15:0] dv_rem_r  [4:8][3];
  logic [8:0]  dv_den_r  [4:8][3];
  logic [7:0]  dv_q_r    [4:8][3];
  logic        dv_sat_r  [4:8][3];
  logic [7:0]  b_nxt   [3];
  logic [7:0]  xnd_nxt [3];
  logic [15:0] num_nxt [3];
  logic [8:0]  den_nxt [3];
  logic [15:0] dv_rem_nxt [5:8][3];
  logic [7:0]  dv_q_nxt   [5:8][3];
  logic        dv_sat_nxt [5:8][3];
  logic [7:0]  s9_x_r   [3];
  logic [7:0]  s9_x_nxt [3];
  logic [7:0]  s10_m_r   [3];
  logic [7:0]  s10_m_nxt [3];
  out_beat_t   out_r;
  out_beat_t   out_nxt;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= RESET_MODE;
      opacity_r <= RESET_OPACITY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_MODE:    mode_r    <= cfg_data[3:0];
        CFG_IDX_OPACITY: opacity_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables, a stage moves when empty or when the next one moves
  always_comb begin
    en[PIPE_DEPTH] = !v_r[PIPE_DEPTH] || out_ready;
    for (int i = PIPE_DEPTH - 1; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[PIPE_DEPTH];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int i = 2; i <= PIPE_DEPTH; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // normal and erase results
  always_comb begin
    s3_base_nxt = s2_d_r;
    case (mode_r)
      BM_ERASE: begin
        for (int k = 0; k < 4; k++) begin
          s3_base_nxt[8*k +: 8] = mul8(s2_d_r[8*k +: 8], ~s2_sa_r);
        end
      end
      BM_NORMAL: begin
        if (s2_sa_r != 8'd0) begin
          for (int k = 0; k < 4; k++) begin
            s3_base_nxt[8*k +: 8] = mul8(s2_s_r[8*k +: 8], opacity_r)
                                  + mul8(s2_d_r[8*k +: 8], ~s2_sa_r);
          end
        end
      end
      default: ;
    endcase
  end

  // stages 1 to 3: capture, reciprocal lookup, unpremultiply
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d_r    <= in_data.dest_pixel;
      s1_s_r    <= in_data.src_pixel;
      s1_last_r <= in_data.last_in_run;
    end
    if (en[2]) begin
      s2_d_r    <= s1_d_r;
      s2_s_r    <= s1_s_r;
      s2_last_r <= s1_last_r;
      s2_gate_r <= (s1_d_r & s1_s_r) != 32'd0;
      s2_invd_r <= INV_TAB[s1_d_r[31:24]][23:0];
      s2_invs_r <= INV_TAB[s1_s_r[31:24]][23:0];
      s2_sa_r   <= mul8(s1_s_r[31:24], opacity_r);
    end
    if (en[3]) begin
      s3_d_r    <= s2_d_r;
      s3_s_r    <= s2_s_r;
      s3_last_r <= s2_last_r;
      s3_gate_r <= s2_gate_r;
      s3_ud_r   <= unpremul(s2_d_r, s2_invd_r);
      s3_us_r   <= unpremul(s2_s_r, s2_invs_r);
      s3_base_r <= s3_base_nxt;
      s3_kb_r   <= mul8(~s2_d_r[31:24], s2_sa_r);
    end
  end

  // stage 4: behind result, mode function set-up per channel
  always_comb begin
    logic [31:0] behind;
    logic [7:0]  b;
    logic [7:0]  sv;
    logic [7:0]  mr;
    logic [8:0]  sum9;
    behind = s3_d_r;
    if (s3_s_r[31:24] != 8'd0 && s3_d_r[31:24] != 8'hFF) begin
      for (int k = 0; k < 4; k++) begin
        behind[8*k +: 8] = mul8(s3_s_r[8*k +: 8], s3_kb_r) + s3_d_r[8*k +: 8];
      end
    end
    ctx_nxt.last    = s3_last_r;
    ctx_nxt.use_sep = s3_gate_r && (mode_r >= BM_MULTIPLY) && (mode_r <= BM_RECOLOR);
    ctx_nxt.simp    = (mode_r == BM_BEHIND) ? behind : s3_base_r;
    ctx_nxt.ua      = s3_ud_r[31:24];
    ctx_nxt.a       = mul8(s3_us_r[31:24], opacity_r);
    for (int c = 0; c < 3; c++) begin
      b    = s3_ud_r[8*c +: 8];
      sv   = s3_us_r[8*c +: 8];
      mr   = (mode_r == BM_SCREEN) ? mul8(~b, ~sv) : mul8(b, sv);
      sum9 = {1'b0, b} + {1'b0, sv};
      b_nxt[c] = b;
      case (mode_r)
        BM_MULTIPLY: xnd_nxt[c] = mr;
        BM_SCREEN:   xnd_nxt[c] = ~mr;
        BM_DARKEN:   xnd_nxt[c] = (b < sv) ? b : sv;
        BM_LIGHTEN:  xnd_nxt[c] = (b > sv) ? b : sv;
        BM_SUBTRACT: xnd_nxt[c] = (b > sv) ? (b - sv) : 8'd0;
        BM_ADD:      xnd_nxt[c] = sum9[8] ? 8'hFF : sum9[7:0];
        default:     xnd_nxt[c] = sv;
      endcase
      case (mode_r)
        BM_DIVIDE: begin
          num_nxt[c] = {b, 8'b0} + {9'b0, sv[7:1]};
          den_nxt[c] = {1'b0, sv} + 9'd1;
        end
        BM_BURN: begin
          num_nxt[c] = {~b, 8'b0};
          den_nxt[c] = {1'b0, sv} + 9'd1;
        end
        BM_DODGE: begin
          num_nxt[c] = {b, 8'b0};
          den_nxt[c] = 9'd256 - {1'b0, sv};
        end
        default: begin
          num_nxt[c] = {b, 8'b0};
          den_nxt[c] = 9'd1;
        end
      endcase
    end
  end

  // stages 5 to 8: quotient two bits a stage, overflow flag in stage 5
  always_comb begin
    logic [17:0] st;
    for (int j = 5; j <= 8; j++) begin
      for (int c = 0; c < 3; c++) begin
        st = div_two(dv_rem_r[j-1][c], dv_den_r[j-1][c], 3'(17 - 2*j));
        dv_rem_nxt[j][c] = st[15:0];
        dv_q_nxt[j][c]   = {dv_q_r[j-1][c][5:0], st[17:16]};
        dv_sat_nxt[j][c] = (j == 5) ?
                           ({1'b0, dv_rem_r[j-1][c]} >= {dv_den_r[j-1][c], 8'b0}) :
                           dv_sat_r[j-1][c];
      end
    end
  end

  // stages 9 to 11: final mode value, alpha mix, premultiply
  always_comb begin
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] v;
    logic [16:0] s;
    logic        sat;
    logic [7:0]  q;
    for (int c = 0; c < 3; c++) begin
      sat = dv_sat_r[8][c];
      q   = dv_q_r[8][c];
      case (mode_r)
        BM_DIVIDE, BM_DODGE: s9_x_nxt[c] = sat ? 8'hFF : q;
        BM_BURN:             s9_x_nxt[c] = (sat || q == 8'hFF) ? 8'd0 : ~q;
        default:             s9_x_nxt[c] = sep_xnd_r[8][c];
      endcase
      p1 = s9_x_r[c] * ctx_r[9].a;
      p2 = sep_b_r[9][c] * (8'd255 - ctx_r[9].a);
      s10_m_nxt[c] = rnd255({1'b0, p1} + {1'b0, p2} + 17'h80);
    end
    out_nxt.last_out  = ctx_r[10].last;
    out_nxt.out_pixel = ctx_r[10].simp;
    if (ctx_r[10].use_sep) begin
      out_nxt.out_pixel[31:24] = ctx_r[10].ua;
      for (int c = 0; c < 3; c++) begin
        v = s10_m_r[c] * ctx_r[10].ua;
        s = {1'b0, v} + {9'b0, v[15:8]} + 17'h80;
        out_nxt.out_pixel[8*c +: 8] = s[15:8];
      end
    end
  end

  // separable pipe registers
  always_ff @(posedge clk) begin
    if (en[4]) begin
      ctx_r[4] <= ctx_nxt;
      for (int c = 0; c < 3; c++) begin
        sep_b_r[4][c]   <= b_nxt[c];
        sep_xnd_r[4][c] <= xnd_nxt[c];
        dv_rem_r[4][c]  <= num_nxt[c];
        dv_den_r[4][c]  <= den_nxt[c];
        dv_q_r[4][c]    <= 8'd0;
        dv_sat_r[4][c]  <= 1'b0;
      end
    end
    for (int j = 5; j <= PIPE_DEPTH - 1; j++) begin
      if (en[j]) begin
        ctx_r[j] <= ctx_r[j-1];
      end
    end
    for (int j = 5; j <= 9; j++) begin
      if (en[j]) begin
        for (int c = 0; c < 3; c++) begin
          sep_b_r[j][c] <= sep_b_r[j-1][c];
        end
      end
    end
    for (int j = 5; j <= 8; j++) begin
      if (en[j]) begin
        for (int c = 0; c < 3; c++) begin
          sep_xnd_r[j][c] <= sep_xnd_r[j-1][c];
          dv_den_r[j][c]  <= dv_den_r[j-1][c];
          dv_rem_r[j][c]  <= dv_rem_nxt[j][c];
          dv_q_r[j][c]    <= dv_q_nxt[j][c];
          dv_sat_r[j][c]  <= dv_sat_nxt[j][c];
        end
      end
    end
    if (en[9]) begin
      for (int c = 0; c < 3; c++) begin
        s9_x_r[c] <= s9_x_nxt[c];
      end
    end
    if (en[10]) begin
      for (int c = 0; c < 3; c++) begin
        s10_m_r[c] <= s10_m_nxt[c];
      end
    end
    if (en[PIPE_DEPTH]) begin
      out_r <= out_nxt;
    end
  end

endmodule

### sv/pbm_checker.sv
// port-level checks for the premultiplied pixel blender, bound to the top level
// depends on pbm_pkg and pixel_blend_modes_premultiplied_assert.svh
`include "pixel_blend_modes_premultiplied_assert.svh"

module pbm_checker import pbm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  logic [4:0] cnt_r;
  logic [4:0] cnt_nxt;

  // beats inside the block
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && in_ready) begin
      cnt_nxt = cnt_nxt + 5'd1;
    end
    if (out_valid && out_ready) begin
      cnt_nxt = cnt_nxt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `PBM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `PBM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)
  `PBM_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready && cnt_r == 5'(PIPE_DEPTH))
  `PBM_ASSERT_NOW(a_no_phantom, out_valid, cnt_r != 5'd0)
  `PBM_ASSERT_NOW(a_depth, in_valid || out_valid, cnt_r <= 5'(PIPE_DEPTH))

endmodule

bind pixel_blend_modes_premultiplied pbm_checker u_pbm_checker (.*);
